// ===== src/sthit_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the multiply-accumulate program for the segment/triangle
// nearest-hit block. No dependencies.
package sthit_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int CRD_W   = 32;
   localparam int VEC_W   = CRD_W + 1;
   localparam int A_W     = VEC_W + 1;
   localparam int WIDE_W  = 2 * VEC_W + 1;
   localparam int LO_W    = VEC_W;
   localparam int HI_W    = WIDE_W - LO_W;
   localparam int B_W     = HI_W + 1;
   localparam int PROD_W  = A_W + B_W;
   localparam int ACC_W   = PROD_W + LO_W + 2;
   localparam int FRAC_W  = FRACTION_BITS + 1;
   localparam int OFF_W   = A_W;
   localparam int SQ_W    = 2 * OFF_W + 2;
   localparam int DIST_W  = 34;
   localparam int THR_W   = 32;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int STEP_W  = 6;
   localparam int CNT_W   = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [STEP_W-1:0] TRI_LAST  = STEP_W'(35);
   localparam logic [STEP_W-1:0] FIN_FIRST = STEP_W'(36);
   localparam logic [STEP_W-1:0] FIN_LAST  = STEP_W'(41);
   localparam logic [FRAC_W-1:0] BEST_RESET = '1;
   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(281474977);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X   = 3'd0,
      CSR_START_Y   = 3'd1,
      CSR_START_Z   = 3'd2,
      CSR_END_X     = 3'd3,
      CSR_END_Y     = 3'd4,
      CSR_END_Z     = 3'd5,
      CSR_THRESHOLD = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] vert_a_x;
      logic signed [CRD_W-1:0] vert_a_y;
      logic signed [CRD_W-1:0] vert_a_z;
      logic signed [CRD_W-1:0] vert_b_x;
      logic signed [CRD_W-1:0] vert_b_y;
      logic signed [CRD_W-1:0] vert_b_z;
      logic signed [CRD_W-1:0] vert_c_x;
      logic signed [CRD_W-1:0] vert_c_y;
      logic signed [CRD_W-1:0] vert_c_z;
      logic                    last_triangle;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic [FRAC_W-1:0]       hit_fraction;
      logic signed [CRD_W-1:0] point_x;
      logic signed [CRD_W-1:0] point_y;
      logic signed [CRD_W-1:0] point_z;
      logic [DIST_W-1:0]       distance;
   } rsp_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] seg_start_x;
      logic signed [CRD_W-1:0] seg_start_y;
      logic signed [CRD_W-1:0] seg_start_z;
      logic signed [CRD_W-1:0] seg_end_x;
      logic signed [CRD_W-1:0] seg_end_y;
      logic signed [CRD_W-1:0] seg_end_z;
      logic [THR_W-1:0]        parallel_threshold;
   } csr_type;

   typedef enum logic [3:0] {
      ASRC_D0, ASRC_D1, ASRC_D2,
      ASRC_E1_0, ASRC_E1_1, ASRC_E1_2,
      ASRC_E2_0, ASRC_E2_1, ASRC_E2_2,
      ASRC_S0, ASRC_S1, ASRC_S2,
      ASRC_OFF0, ASRC_OFF1, ASRC_OFF2
   } a_src_type;

   typedef enum logic [4:0] {
      BSRC_E1_0, BSRC_E1_1, BSRC_E1_2,
      BSRC_E2_0, BSRC_E2_1, BSRC_E2_2,
      BSRC_P0_LO, BSRC_P1_LO, BSRC_P2_LO,
      BSRC_Q0_LO, BSRC_Q1_LO, BSRC_Q2_LO,
      BSRC_P0_HI, BSRC_P1_HI, BSRC_P2_HI,
      BSRC_Q0_HI, BSRC_Q1_HI, BSRC_Q2_HI,
      BSRC_BEST,
      BSRC_OFF0, BSRC_OFF1, BSRC_OFF2
   } b_src_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_P0, DST_P1, DST_P2,
      DST_Q0, DST_Q1, DST_Q2,
      DST_DET, DST_NU, DST_NV, DST_NT,
      DST_OFF0, DST_OFF1, DST_OFF2,
      DST_SQ
   } dest_type;

   typedef struct packed {
      a_src_type a_src;
      b_src_type b_src;
      logic      neg;
      logic      clr;
      logic      rnd;
      dest_type  dest;
   } uop_type;

   typedef struct packed {
      logic    capture;
      logic    issue;
      uop_type uop;
      logic    norm;
      logic    div_init;
      logic    div_step;
      logic    update;
      logic    sqrt_step;
      logic    load_rsp;
      logic    clear_query;
   } cmd_type;

   typedef struct packed {
      logic pass;
      logic last;
      logic hit_seen;
   } sts_type;

   function automatic uop_type mk(input a_src_type a, input b_src_type b, input logic neg,
                                  input logic clr, input logic rnd, input dest_type dest);
      uop_type u;
      u.a_src = a;
      u.b_src = b;
      u.neg   = neg;
      u.clr   = clr;
      u.rnd   = rnd;
      u.dest  = dest;
      return u;
   endfunction

   // p = d x e2, q = s x e1, then det/nu/nv/nt as split dot products,
   // and for the result the rounded offsets and their squares.
   function automatic uop_type prog_rom(input logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         6'd0:  u = mk(ASRC_D1,   BSRC_E2_2,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd1:  u = mk(ASRC_D2,   BSRC_E2_1,  1'b1, 1'b0, 1'b0, DST_P0);
         6'd2:  u = mk(ASRC_D2,   BSRC_E2_0,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd3:  u = mk(ASRC_D0,   BSRC_E2_2,  1'b1, 1'b0, 1'b0, DST_P1);
         6'd4:  u = mk(ASRC_D0,   BSRC_E2_1,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd5:  u = mk(ASRC_D1,   BSRC_E2_0,  1'b1, 1'b0, 1'b0, DST_P2);
         6'd6:  u = mk(ASRC_S1,   BSRC_E1_2,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd7:  u = mk(ASRC_S2,   BSRC_E1_1,  1'b1, 1'b0, 1'b0, DST_Q0);
         6'd8:  u = mk(ASRC_S2,   BSRC_E1_0,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd9:  u = mk(ASRC_S0,   BSRC_E1_2,  1'b1, 1'b0, 1'b0, DST_Q1);
         6'd10: u = mk(ASRC_S0,   BSRC_E1_1,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd11: u = mk(ASRC_S1,   BSRC_E1_0,  1'b1, 1'b0, 1'b0, DST_Q2);
         6'd12: u = mk(ASRC_E1_0, BSRC_P0_LO, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd13: u = mk(ASRC_E1_0, BSRC_P0_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd14: u = mk(ASRC_E1_1, BSRC_P1_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd15: u = mk(ASRC_E1_1, BSRC_P1_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd16: u = mk(ASRC_E1_2, BSRC_P2_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd17: u = mk(ASRC_E1_2, BSRC_P2_HI, 1'b0, 1'b0, 1'b0, DST_DET);
         6'd18: u = mk(ASRC_S0,   BSRC_P0_LO, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd19: u = mk(ASRC_S0,   BSRC_P0_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd20: u = mk(ASRC_S1,   BSRC_P1_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd21: u = mk(ASRC_S1,   BSRC_P1_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd22: u = mk(ASRC_S2,   BSRC_P2_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd23: u = mk(ASRC_S2,   BSRC_P2_HI, 1'b0, 1'b0, 1'b0, DST_NU);
         6'd24: u = mk(ASRC_D0,   BSRC_Q0_LO, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd25: u = mk(ASRC_D0,   BSRC_Q0_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd26: u = mk(ASRC_D1,   BSRC_Q1_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd27: u = mk(ASRC_D1,   BSRC_Q1_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd28: u = mk(ASRC_D2,   BSRC_Q2_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd29: u = mk(ASRC_D2,   BSRC_Q2_HI, 1'b0, 1'b0, 1'b0, DST_NV);
         6'd30: u = mk(ASRC_E2_0, BSRC_Q0_LO, 1'b0, 1'b1, 1'b0, DST_NONE);
         6'd31: u = mk(ASRC_E2_0, BSRC_Q0_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd32: u = mk(ASRC_E2_1, BSRC_Q1_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd33: u = mk(ASRC_E2_1, BSRC_Q1_HI, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd34: u = mk(ASRC_E2_2, BSRC_Q2_LO, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd35: u = mk(ASRC_E2_2, BSRC_Q2_HI, 1'b0, 1'b0, 1'b0, DST_NT);
         6'd36: u = mk(ASRC_D0,   BSRC_BEST,  1'b0, 1'b1, 1'b1, DST_OFF0);
         6'd37: u = mk(ASRC_D1,   BSRC_BEST,  1'b0, 1'b1, 1'b1, DST_OFF1);
         6'd38: u = mk(ASRC_D2,   BSRC_BEST,  1'b0, 1'b1, 1'b1, DST_OFF2);
         6'd39: u = mk(ASRC_OFF0, BSRC_OFF0,  1'b0, 1'b1, 1'b0, DST_NONE);
         6'd40: u = mk(ASRC_OFF1, BSRC_OFF1,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd41: u = mk(ASRC_OFF2, BSRC_OFF2,  1'b0, 1'b0, 1'b0, DST_SQ);
         default: u = mk(ASRC_D0, BSRC_E1_0,  1'b0, 1'b1, 1'b0, DST_NONE);
      endcase
      return u;
   endfunction

endpackage

// ===== src/sthit_csr.sv =====
`timescale 1ns / 1ps
// Segment and threshold register file with its write channel.
// Depends on sthit_pkg.
module sthit_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sthit_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                           csr_wdata,
   output sthit_pkg::csr_type                    cfg
);
   import sthit_pkg::*;

   csr_type csr_ff;

   assign csr_ready = 1'b1;
   assign cfg       = csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.seg_start_x        <= '0;
         csr_ff.seg_start_y        <= '0;
         csr_ff.seg_start_z        <= '0;
         csr_ff.seg_end_x          <= '0;
         csr_ff.seg_end_y          <= '0;
         csr_ff.seg_end_z          <= '0;
         csr_ff.parallel_threshold <= THR_RESET;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_START_X:   csr_ff.seg_start_x        <= csr_wdata;
            CSR_START_Y:   csr_ff.seg_start_y        <= csr_wdata;
            CSR_START_Z:   csr_ff.seg_start_z        <= csr_wdata;
            CSR_END_X:     csr_ff.seg_end_x          <= csr_wdata;
            CSR_END_Y:     csr_ff.seg_end_y          <= csr_wdata;
            CSR_END_Z:     csr_ff.seg_end_z          <= csr_wdata;
            CSR_THRESHOLD: csr_ff.parallel_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// ===== src/sthit_dp.sv =====
`timescale 1ns / 1ps
// Datapath: edge vectors, shared two-stage multiply-accumulate, t divider,
// nearest-hit tracking, square root and result register. Depends on sthit_pkg.
module sthit_dp (
   input  logic                clock,
   input  logic                reset,
   input  sthit_pkg::req_type  req_data,
   input  sthit_pkg::csr_type  cfg,
   input  sthit_pkg::cmd_type  cmd,
   output sthit_pkg::sts_type  sts,
   output sthit_pkg::rsp_type  rsp_data
);
   import sthit_pkg::*;

   typedef logic signed [VEC_W-1:0] vec_type;

   logic [CRD_W-1:0] st [3];
   logic [CRD_W-1:0] en [3];
   logic [CRD_W-1:0] va [3];
   logic [CRD_W-1:0] vb [3];
   logic [CRD_W-1:0] vc [3];

   vec_type d_ff  [3];
   vec_type e1_ff [3];
   vec_type e2_ff [3];
   vec_type s_ff  [3];
   logic [WIDE_W-1:0] p_ff [3];
   logic [WIDE_W-1:0] q_ff [3];
   logic signed [OFF_W-1:0] off_ff [3];
   logic [ACC_W-1:0] det_ff, nu_ff, nv_ff, nt_ff;
   logic last_ff;

   logic signed [A_W-1:0]    a_op;
   logic signed [B_W-1:0]    b_op;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     hi_sel;
   logic                     issue_ff, neg_ff, clr_ff, rnd_ff, hi_ff;
   dest_type                 dest_ff;
   logic [ACC_W-1:0]         base, term, acc_in, acc_ff;

   logic [ACC_W-1:0] rem_ff, rem2, rem_in;
   logic             rem_ge, whole_ff;
   logic [FRACTION_BITS-1:0] frac_ff;
   logic [FRAC_W-1:0] tq, best_ff;
   logic              hit_seen_ff;

   logic [SQ_W-1:0] sq_op_ff, root_ff, bit_ff, trial;
   logic            sq_ge;

   logic [OFF_W-1:0] pt_sum [3];
   rsp_type          rsp_ff;

   localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRACTION_BITS - 1);

   function automatic vec_type sdiff(input logic [CRD_W-1:0] a, input logic [CRD_W-1:0] b);
      return {a[CRD_W-1], a} - {b[CRD_W-1], b};
   endfunction

   function automatic logic signed [B_W-1:0] bvec(input vec_type v);
      return {{(B_W-VEC_W){v[VEC_W-1]}}, v};
   endfunction

   function automatic logic signed [B_W-1:0] blo(input logic [WIDE_W-1:0] w);
      return {{(B_W-LO_W){1'b0}}, w[LO_W-1:0]};
   endfunction

   function automatic logic signed [B_W-1:0] bhi(input logic [WIDE_W-1:0] w);
      return {{(B_W-HI_W){w[WIDE_W-1]}}, w[WIDE_W-1:LO_W]};
   endfunction

   always_comb begin
      st[0] = cfg.seg_start_x;  st[1] = cfg.seg_start_y;  st[2] = cfg.seg_start_z;
      en[0] = cfg.seg_end_x;    en[1] = cfg.seg_end_y;    en[2] = cfg.seg_end_z;
      va[0] = req_data.vert_a_x; va[1] = req_data.vert_a_y; va[2] = req_data.vert_a_z;
      vb[0] = req_data.vert_b_x; vb[1] = req_data.vert_b_y; vb[2] = req_data.vert_b_z;
      vc[0] = req_data.vert_c_x; vc[1] = req_data.vert_c_y; vc[2] = req_data.vert_c_z;
   end

   // Stage 1: operand select and multiply
   always_comb begin
      case (cmd.uop.a_src)
         ASRC_D0:   a_op = {d_ff[0][VEC_W-1], d_ff[0]};
         ASRC_D1:   a_op = {d_ff[1][VEC_W-1], d_ff[1]};
         ASRC_D2:   a_op = {d_ff[2][VEC_W-1], d_ff[2]};
         ASRC_E1_0: a_op = {e1_ff[0][VEC_W-1], e1_ff[0]};
         ASRC_E1_1: a_op = {e1_ff[1][VEC_W-1], e1_ff[1]};
         ASRC_E1_2: a_op = {e1_ff[2][VEC_W-1], e1_ff[2]};
         ASRC_E2_0: a_op = {e2_ff[0][VEC_W-1], e2_ff[0]};
         ASRC_E2_1: a_op = {e2_ff[1][VEC_W-1], e2_ff[1]};
         ASRC_E2_2: a_op = {e2_ff[2][VEC_W-1], e2_ff[2]};
         ASRC_S0:   a_op = {s_ff[0][VEC_W-1], s_ff[0]};
         ASRC_S1:   a_op = {s_ff[1][VEC_W-1], s_ff[1]};
         ASRC_S2:   a_op = {s_ff[2][VEC_W-1], s_ff[2]};
         ASRC_OFF0: a_op = off_ff[0];
         ASRC_OFF1: a_op = off_ff[1];
         ASRC_OFF2: a_op = off_ff[2];
         default:   a_op = '0;
      endcase
      case (cmd.uop.b_src)
         BSRC_E1_0:  b_op = bvec(e1_ff[0]);
         BSRC_E1_1:  b_op = bvec(e1_ff[1]);
         BSRC_E1_2:  b_op = bvec(e1_ff[2]);
         BSRC_E2_0:  b_op = bvec(e2_ff[0]);
         BSRC_E2_1:  b_op = bvec(e2_ff[1]);
         BSRC_E2_2:  b_op = bvec(e2_ff[2]);
         BSRC_P0_LO: b_op = blo(p_ff[0]);
         BSRC_P1_LO: b_op = blo(p_ff[1]);
         BSRC_P2_LO: b_op = blo(p_ff[2]);
         BSRC_Q0_LO: b_op = blo(q_ff[0]);
         BSRC_Q1_LO: b_op = blo(q_ff[1]);
         BSRC_Q2_LO: b_op = blo(q_ff[2]);
         BSRC_P0_HI: b_op = bhi(p_ff[0]);
         BSRC_P1_HI: b_op = bhi(p_ff[1]);
         BSRC_P2_HI: b_op = bhi(p_ff[2]);
         BSRC_Q0_HI: b_op = bhi(q_ff[0]);
         BSRC_Q1_HI: b_op = bhi(q_ff[1]);
         BSRC_Q2_HI: b_op = bhi(q_ff[2]);
         BSRC_BEST:  b_op = {{(B_W-FRAC_W){1'b0}}, best_ff};
         BSRC_OFF0:  b_op = {off_ff[0][OFF_W-1], off_ff[0]};
         BSRC_OFF1:  b_op = {off_ff[1][OFF_W-1], off_ff[1]};
         BSRC_OFF2:  b_op = {off_ff[2][OFF_W-1], off_ff[2]};
         default:    b_op = '0;
      endcase
      hi_sel  = cmd.uop.b_src inside {BSRC_P0_HI, BSRC_P1_HI, BSRC_P2_HI,
                                      BSRC_Q0_HI, BSRC_Q1_HI, BSRC_Q2_HI};
      prod_in = a_op * b_op;
   end

   // Stage 2: accumulate; upper halves of wide operands weigh 2^LO_W
   always_comb begin
      base   = clr_ff ? (rnd_ff ? ROUND : '0) : acc_ff;
      term   = hi_ff ? (ACC_W'(prod_ff) << LO_W) : ACC_W'(prod_ff);
      acc_in = neg_ff ? base - term : base + term;
   end

   // t divider, one quotient bit per cycle
   always_comb begin
      rem2   = rem_ff << 1;
      rem_ge = rem2 >= det_ff;
      rem_in = rem_ge ? rem2 - det_ff : rem2;
      tq     = {whole_ff, frac_ff};
   end

   // square root, two radicand bits per cycle
   always_comb begin
      trial = root_ff + bit_ff;
      sq_ge = sq_op_ff >= trial;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt_sum[i] = {{(OFF_W-CRD_W){st[i][CRD_W-1]}}, st[i]} + off_ff[i];
      end
   end

   always_comb begin
      sts.last     = last_ff;
      sts.hit_seen = hit_seen_ff;
      sts.pass     = (det_ff != '0) && (det_ff >= ACC_W'(cfg.parallel_threshold))
                     && !nu_ff[ACC_W-1] && (nu_ff <= det_ff)
                     && !nv_ff[ACC_W-1] && ((nu_ff + nv_ff) <= det_ff)
                     && !nt_ff[ACC_W-1] && (nt_ff <= det_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         best_ff     <= BEST_RESET;
         hit_seen_ff <= 1'b0;
      end else begin
         issue_ff <= cmd.issue;
         if (cmd.update && (tq < best_ff)) begin
            best_ff     <= tq;
            hit_seen_ff <= 1'b1;
         end
         if (cmd.clear_query) begin
            best_ff     <= BEST_RESET;
            hit_seen_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i]  <= sdiff(en[i], st[i]);
            e1_ff[i] <= sdiff(vb[i], va[i]);
            e2_ff[i] <= sdiff(vc[i], va[i]);
            s_ff[i]  <= sdiff(st[i], va[i]);
         end
         last_ff <= req_data.last_triangle;
      end

      prod_ff <= prod_in;
      neg_ff  <= cmd.uop.neg;
      clr_ff  <= cmd.uop.clr;
      rnd_ff  <= cmd.uop.rnd;
      hi_ff   <= hi_sel;
      dest_ff <= cmd.issue ? cmd.uop.dest : DST_NONE;

      if (issue_ff) begin
         acc_ff <= acc_in;
      end
      case (dest_ff)
         DST_P0:   p_ff[0] <= acc_in[WIDE_W-1:0];
         DST_P1:   p_ff[1] <= acc_in[WIDE_W-1:0];
         DST_P2:   p_ff[2] <= acc_in[WIDE_W-1:0];
         DST_Q0:   q_ff[0] <= acc_in[WIDE_W-1:0];
         DST_Q1:   q_ff[1] <= acc_in[WIDE_W-1:0];
         DST_Q2:   q_ff[2] <= acc_in[WIDE_W-1:0];
         DST_DET:  det_ff  <= acc_in;
         DST_NU:   nu_ff   <= acc_in;
         DST_NV:   nv_ff   <= acc_in;
         DST_NT:   nt_ff   <= acc_in;
         DST_OFF0: off_ff[0] <= acc_in[FRACTION_BITS +: OFF_W];
         DST_OFF1: off_ff[1] <= acc_in[FRACTION_BITS +: OFF_W];
         DST_OFF2: off_ff[2] <= acc_in[FRACTION_BITS +: OFF_W];
         DST_SQ: begin
            sq_op_ff <= acc_in[SQ_W-1:0];
            root_ff  <= '0;
            bit_ff   <= SQ_W'(1) << (SQ_W - 2);
         end
         default: ;
      endcase

      // flip all four so the determinant is non-negative
      if (cmd.norm && det_ff[ACC_W-1]) begin
         det_ff <= -det_ff;
         nu_ff  <= -nu_ff;
         nv_ff  <= -nv_ff;
         nt_ff  <= -nt_ff;
      end

      if (cmd.div_init) begin
         whole_ff <= (nt_ff == det_ff);
         rem_ff   <= (nt_ff == det_ff) ? '0 : nt_ff;
         frac_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         frac_ff <= {frac_ff[FRACTION_BITS-2:0], rem_ge};
      end

      if (cmd.sqrt_step) begin
         if (sq_ge) begin
            sq_op_ff <= sq_op_ff - trial;
            root_ff  <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      if (cmd.load_rsp) begin
         rsp_ff.hit <= hit_seen_ff;
         if (hit_seen_ff) begin
            rsp_ff.hit_fraction <= best_ff;
            rsp_ff.point_x      <= pt_sum[0][CRD_W-1:0];
            rsp_ff.point_y      <= pt_sum[1][CRD_W-1:0];
            rsp_ff.point_z      <= pt_sum[2][CRD_W-1:0];
            rsp_ff.distance     <= root_ff[DIST_W-1:0];
         end else begin
            rsp_ff.hit_fraction <= '0;
            rsp_ff.point_x      <= st[0];
            rsp_ff.point_y      <= st[1];
            rsp_ff.point_z      <= st[2];
            rsp_ff.distance     <= '0;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/sthit_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the multiply-accumulate program, divider, square root
// and result transfer. Depends on sthit_pkg.
module sthit_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sthit_pkg::cmd_type cmd,
   input  sthit_pkg::sts_type sts
);
   import sthit_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_MAC    = 12'b000000000010,
      S_DRAIN  = 12'b000000000100,
      S_NORM   = 12'b000000001000,
      S_CHECK  = 12'b000000010000,
      S_DIV    = 12'b000000100000,
      S_UPDATE = 12'b000001000000,
      S_DONE   = 12'b000010000000,
      S_FIN    = 12'b000100000000,
      S_FDRAIN = 12'b001000000000,
      S_SQRT   = 12'b010000000000,
      S_EMIT   = 12'b100000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.uop      = prog_rom(step_ff);
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = S_MAC;
            end
         end
         S_MAC: begin
            cmd.issue = 1'b1;
            if (step_ff == TRI_LAST) begin
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DRAIN: state_in = S_NORM;
         S_NORM: begin
            cmd.norm = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.pass) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(FRACTION_BITS - 1)) begin
               state_in = S_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (sts.hit_seen) begin
               step_in  = FIN_FIRST;
               state_in = S_FIN;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_FIN: begin
            cmd.issue = 1'b1;
            if (step_ff == FIN_LAST) begin
               state_in = S_FDRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FDRAIN: begin
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_rsp    = 1'b1;
               cmd.clear_query = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/segment_triangle_nearest_hit.sv =====
`timescale 1ns / 1ps
// Triangle stream: each triangle runs 36 products on the single shared 34x35 multiplier, and one
// that passes the bounds tests then runs the t divider before the nearest-hit update.
// A query's last triangle then loads the result register; with a hit it first adds
// 6 more products, a drain state and the square root.
// The next triangle transfer is taken while a result waits; a waiting result holds the next load.
// Reset (synchronous, active high) clears controller and nearest-hit state, loads register resets.
module segment_triangle_nearest_hit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sthit_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sthit_pkg::rsp_type               rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sthit_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_wdata
);
   import sthit_pkg::*;

   csr_type cfg;
   cmd_type cmd;
   sts_type sts;

   sthit_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sthit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   sthit_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== dv/tb_segment_triangle_nearest_hit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for segment_triangle_nearest_hit: streams triangle queries,
// predicts the nearest crossing with exact wide arithmetic and checks every result.
// Depends on sthit_pkg and the block itself.
module tb_segment_triangle_nearest_hit;
   import sthit_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int U = 65536;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   segment_triangle_nearest_hit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata));

   // mirrored registers and query state
   logic signed [31:0] seg_start [3];
   logic signed [31:0] seg_end [3];
   logic [31:0] threshold;
   logic [FRAC_W-1:0] nearest;
   logic any_crossing;

   req_type triangle_queue[$];
   rsp_type pending_answers[$];
   int errors = 0;
   int accepted = 0;
   bit calm = 0;
   bit hold_rsp = 0;
   int req_gap = 0, rsp_gap = 0;
   longint cycles = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Moller-Trumbore on exact integers; returns 1 and the quantized t on a crossing
   function automatic bit crossing_fraction(input req_type r, output logic [FRAC_W-1:0] tq);
      logic signed [31:0] va [3], vb [3], vc [3];
      logic signed [127:0] d [3], e1 [3], e2 [3], s [3], p [3], q [3];
      logic signed [127:0] det, nu, nv, nt, thr, quo;
      va = '{r.vert_a_x, r.vert_a_y, r.vert_a_z};
      vb = '{r.vert_b_x, r.vert_b_y, r.vert_b_z};
      vc = '{r.vert_c_x, r.vert_c_y, r.vert_c_z};
      tq = '0;
      for (int i = 0; i < 3; i++) begin
         d[i]  = 128'(seg_end[i]) - 128'(seg_start[i]);
         e1[i] = 128'(vb[i]) - 128'(va[i]);
         e2[i] = 128'(vc[i]) - 128'(va[i]);
         s[i]  = 128'(seg_start[i]) - 128'(va[i]);
      end
      p[0] = d[1] * e2[2] - d[2] * e2[1];
      p[1] = d[2] * e2[0] - d[0] * e2[2];
      p[2] = d[0] * e2[1] - d[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
      nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
      nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
      nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      if (det == 0) return 0;
      if (det < 0) begin
         det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      thr = $signed({96'b0, threshold});
      if (det < thr) return 0;
      if (nu < 0 || nu > det) return 0;
      if (nv < 0 || nu + nv > det) return 0;
      if (nt < 0 || nt > det) return 0;
      if (nt == det) tq = FRAC_W'(1 << FRACTION_BITS);
      else begin
         quo = (nt <<< FRACTION_BITS) / det;
         tq = quo[FRAC_W-1:0];
      end
      return 1;
   endfunction

   function automatic rsp_type query_answer();
      rsp_type a;
      logic signed [63:0] prod, off;
      logic [63:0] mag, root, cand;
      logic [127:0] sq;
      logic signed [31:0] pt [3];
      a = '0;
      if (!any_crossing) begin
         a.point_x = seg_start[0]; a.point_y = seg_start[1]; a.point_z = seg_start[2];
         return a;
      end
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         prod = (64'(seg_end[i]) - 64'(seg_start[i])) * $signed({47'b0, nearest});
         off = (prod + 64'sd32768) >>> FRACTION_BITS;
         mag = off < 0 ? -off : off;
         pt[i] = seg_start[i] + off[31:0];
         sq += 128'(mag) * 128'(mag);
      end
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= sq) root = cand;
      end
      a.hit = 1'b1;
      a.hit_fraction = nearest;
      a.point_x = pt[0]; a.point_y = pt[1]; a.point_z = pt[2];
      a.distance = root[DIST_W-1:0];
      return a;
   endfunction

   // sender
   always @(posedge clock) begin
      logic take;
      take = 0;
      if (reset) req_valid <= 0;
      else if (!req_valid || req_ready) begin
         if (req_gap > 0) req_gap--;
         else if (triangle_queue.size() > 0) begin
            if (!calm && $urandom_range(0, 11) == 0) req_gap = $urandom_range(0, 18);
            else take = 1;
         end
         req_valid <= take;
         if (take) req_data <= triangle_queue.pop_front();
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_rsp) rsp_ready <= 0;
      else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 18);
         rsp_ready <= 0;
      end else rsp_ready <= 1;
   end

   // monitor and prediction
   always @(posedge clock) begin
      logic [FRAC_W-1:0] tq;
      rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("segment_triangle_nearest_hit test failed");
         $finish;
      end
      if (reset) begin
         seg_start = '{0, 0, 0};
         seg_end = '{0, 0, 0};
         threshold = THR_RESET;
         nearest = BEST_RESET;
         any_crossing = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_X:   seg_start[0] = csr_wdata;
               CSR_START_Y:   seg_start[1] = csr_wdata;
               CSR_START_Z:   seg_start[2] = csr_wdata;
               CSR_END_X:     seg_end[0] = csr_wdata;
               CSR_END_Y:     seg_end[1] = csr_wdata;
               CSR_END_Z:     seg_end[2] = csr_wdata;
               CSR_THRESHOLD: threshold = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            accepted++;
            if (crossing_fraction(req_data, tq) && tq < nearest) begin
               nearest = tq;
               any_crossing = 1;
            end
            if (req_data.last_triangle) begin
               pending_answers.push_back(query_answer());
               nearest = BEST_RESET;
               any_crossing = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               errors++;
               $display("%0t unexpected result %p", $time, rsp_data);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.hit_fraction !== want.hit_fraction ||
                   rsp_data.point_x !== want.point_x || rsp_data.point_y !== want.point_y ||
                   rsp_data.point_z !== want.point_z || rsp_data.distance !== want.distance)
               begin
                  errors++;
                  $display("%0t mismatch: expected %p actual %p", $time, want, rsp_data);
               end
            end
         end
      end
   end

   // long receiver stall while the sender keeps offering
   initial begin
      wait (accepted >= 600);
      @(posedge clock) hold_rsp <= 1;
      repeat (3000) @(posedge clock);
      hold_rsp <= 0;
   end

   function automatic req_type tri_at(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                      input bit last);
      req_type r;
      r = '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
      return r;
   endfunction

   function automatic int jitter(input int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_segment(input int sx, sy, sz, ex, ey, ez);
      write_reg(CSR_START_X, sx); write_reg(CSR_START_Y, sy); write_reg(CSR_START_Z, sz);
      write_reg(CSR_END_X, ex);   write_reg(CSR_END_Y, ey);   write_reg(CSR_END_Z, ez);
   endtask

   // no result is owed for an unfinished query, so allow the last triangle to clear
   task automatic drain();
      do @(posedge clock);
      while (triangle_queue.size() > 0 || req_valid || pending_answers.size() > 0);
      repeat (150) @(posedge clock);
   endtask

   // triangles around a point on the segment, plus some full-range noise
   task automatic random_queries(input int count, input int span, input bit wide_noise);
      int px, py, pz, f, n;
      logic signed [63:0] dd [3];
      int pt [3];
      n = 0;
      while (n < count) begin
         int len;
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            bit last;
            last = (k == len - 1);
            if ($urandom_range(0, wide_noise ? 2 : 4) == 0) begin
               triangle_queue.push_back(tri_at($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, last));
            end else begin
               f = $urandom_range(0, 256);
               for (int i = 0; i < 3; i++) begin
                  dd[i] = 64'(seg_end[i]) - 64'(seg_start[i]);
                  pt[i] = seg_start[i] + int'((dd[i] * f) >>> 8);
               end
               px = pt[0]; py = pt[1]; pz = pt[2];
               triangle_queue.push_back(tri_at(
                  px + jitter(span), py + jitter(span), pz + jitter(span),
                  px + jitter(span), py + jitter(span), pz + jitter(span),
                  px + jitter(span), py + jitter(span), pz + jitter(span), last));
            end
            n++;
         end
      end
   endtask

   initial begin
      reset = 1;
      csr_valid = 0;
      csr_index = CSR_START_X;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // reset registers: zero-length segment never crosses
      triangle_queue.push_back(tri_at(-U, -U, 0, U, -U, 0, 0, U, 0, 1));
      drain();

      set_segment(0, 0, -U, 0, 0, U);
      write_reg(CSR_UNUSED, 32'hffff_ffff);
      triangle_queue.push_back(tri_at(-U, -U, 0, U, -U, 0, 0, U, 0, 1));       // midpoint
      triangle_queue.push_back(tri_at(-U, -U, -U, U, -U, -U, 0, U, -U, 1));    // at start
      triangle_queue.push_back(tri_at(-U, -U, U, U, -U, U, 0, U, U, 1));       // at end
      triangle_queue.push_back(tri_at(0, 0, 0, U, 0, 0, 0, U, 0, 1));          // on a vertex
      triangle_queue.push_back(tri_at(-U, 0, 0, U, 0, 0, 0, U, 0, 1));         // on an edge
      triangle_queue.push_back(tri_at(0, -U, -U, 0, U, -U, 0, 0, U, 1));       // parallel
      triangle_queue.push_back(tri_at(-U, -U, 2*U, U, -U, 2*U, 0, U, 2*U, 1)); // past end
      triangle_queue.push_back(tri_at(-1, -1, 0, 1, -1, 0, 0, 1, 0, 1));       // det too small
      triangle_queue.push_back(tri_at(-U, -U, 0, 0, U, 0, U, -U, 0, 1));       // reversed winding
      triangle_queue.push_back(tri_at(-U, -U, U/4, U, -U, U/4, 0, U, U/4, 0));
      triangle_queue.push_back(tri_at(-U, -U, -U/2, U, -U, -U/2, 0, U, -U/2, 0));
      triangle_queue.push_back(tri_at(-2*U, -U, -U/2, U, -U, -U/2, 0, 2*U, -U/2, 1)); // tie
      triangle_queue.push_back(tri_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h7fff_ffff, 1));
      triangle_queue.push_back(tri_at(5, 5, 5, 5, 5, 5, 5, 5, 5, 1));          // degenerate
      drain();

      write_reg(CSR_THRESHOLD, 32'd0);
      triangle_queue.push_back(tri_at(-1, -1, 0, 1, -1, 0, 0, 1, 0, 1));
      triangle_queue.push_back(tri_at(0, -U, -U, 0, U, -U, 0, 0, U, 1));
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         set_segment(jitter(1 << 20), jitter(1 << 20), jitter(1 << 20),
                     jitter(1 << 20), jitter(1 << 20), jitter(1 << 20));
         case (ph)
            0: write_reg(CSR_THRESHOLD, THR_RESET);
            1: write_reg(CSR_THRESHOLD, 32'hffff_ffff);
            2: write_reg(CSR_THRESHOLD, 32'd0);
            default: write_reg(CSR_THRESHOLD, $urandom);
         endcase
         random_queries(220, 1 << 18, 0);
         drain();
      end

      // segment corner to corner across the whole coordinate range
      set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      write_reg(CSR_THRESHOLD, $urandom);
      random_queries(150, 1 << 30, 1);
      drain();
      set_segment(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      random_queries(100, 1 << 28, 1);
      drain();

      calm = 1;
      set_segment(jitter(1 << 16), jitter(1 << 16), jitter(1 << 16),
                  jitter(1 << 22), jitter(1 << 22), jitter(1 << 22));
      write_reg(CSR_THRESHOLD, THR_RESET);
      random_queries(200, 1 << 17, 0);
      drain();

      if (errors == 0) $display("segment_triangle_nearest_hit test passed");
      else $display("segment_triangle_nearest_hit test failed");
      $finish;
   end
endmodule
